[rtl/ordered_list_engine_defines.svh]
// ----------------------------------------------------------------------------
// ordered list engine assertion macros
// shared concurrent check templates, clocked on aclk, off during reset
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define OLE_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// same-cycle implication
`define OLE_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OLE_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ole_pkg.sv]
// ----------------------------------------------------------------------------
// ole_pkg
// opcodes, status codes and the controller/datapath interface types
// ----------------------------------------------------------------------------
package ole_pkg;

    localparam int OPCODE_W   = 3;
    localparam int VALUE_W    = 32;
    localparam int POSITION_W = 4;
    localparam int STATUS_W   = 3;
    localparam int SLOT_W     = 4;
    localparam int LENGTH_W   = 5;

    // a list request never returns more results than this
    localparam int MAX_RESULTS = 16;

    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_INSERT_AFTER = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_DELETE       = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_SEARCH       = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_LIST         = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    // pointer update
    localparam logic [2:0] PTR_HOLD  = 3'd0;
    localparam logic [2:0] PTR_ZERO  = 3'd1;
    localparam logic [2:0] PTR_COUNT = 3'd2;
    localparam logic [2:0] PTR_INC   = 3'd3;
    localparam logic [2:0] PTR_DEC   = 3'd4;

    // insert stop point update
    localparam logic [1:0] STOP_HOLD  = 2'd0;
    localparam logic [1:0] STOP_ZERO  = 2'd1;
    localparam logic [1:0] STOP_COUNT = 2'd2;
    localparam logic [1:0] STOP_POS1  = 2'd3;

    // memory read address relative to the pointer
    localparam logic [1:0] RD_PTR  = 2'd0;
    localparam logic [1:0] RD_PREV = 2'd1;
    localparam logic [1:0] RD_NEXT = 2'd2;

    typedef struct packed {
        logic                latch_in;
        logic [2:0]          ptr_op;
        logic [1:0]          stop_op;
        logic                mem_rd;
        logic [1:0]          rd_sel;
        logic                mem_wr;
        logic                wr_value;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                out_load;
        logic                out_list;
        logic [STATUS_W-1:0] status;
        logic                slot_en;
    } cmd_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic                empty;
        logic                full;
        logic                pos_beyond;
        logic                at_stop;
        logic                at_end;
        logic                del_end;
        logic                match;
        logic                list_last;
        logic                out_free;
    } stat_t;

endpackage

[rtl/ordered_list_engine.sv]
// ----------------------------------------------------------------------------
// ordered list engine
// bounded ordered list of signed 32-bit values driven by one request per item
// ----------------------------------------------------------------------------
// One request is taken at a time, while the previous result may still wait
// in the output register. All walks go through a single-port entry memory
// with a registered read, one read and one write or compare per entry
// visited: push back writes the new value directly, push front and
// insert-after first move each later entry one slot toward the back, search
// reads and compares entries from the front, delete also shifts each later
// entry up by one, and list gives one result per entry, holding while the
// output side stalls.
// the entry count alone marks which memory words are live.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ole_pkg::OPCODE_W-1:0]        s_opcode,
    input  logic signed [ole_pkg::VALUE_W-1:0]  s_value,
    input  logic [ole_pkg::POSITION_W-1:0]      s_position,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ole_pkg::STATUS_W-1:0]        m_status,
    output logic signed [ole_pkg::VALUE_W-1:0]  m_element,
    output logic [ole_pkg::SLOT_W-1:0]          m_slot_index,
    output logic [ole_pkg::LENGTH_W-1:0]        m_length,
    output logic                                m_last
);

    ole_pkg::cmd_t  cmd;
    ole_pkg::stat_t stat;

    ole_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ole_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_opcode     (s_opcode),
        .s_value      (s_value),
        .s_position   (s_position),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_element    (m_element),
        .m_slot_index (m_slot_index),
        .m_length     (m_length),
        .m_last       (m_last)
    );

endmodule

[rtl/ole_ctrl.sv]
// ----------------------------------------------------------------------------
// ole_ctrl
// sequencer that walks the list for each request and drives the datapath
// ----------------------------------------------------------------------------
module ole_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ole_pkg::stat_t stat,
    output ole_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECIDE   = 4'd1;
    localparam logic [3:0] S_INS_CHK  = 4'd2;
    localparam logic [3:0] S_INS_WR   = 4'd3;
    localparam logic [3:0] S_SCAN_RD  = 4'd4;
    localparam logic [3:0] S_SCAN_CMP = 4'd5;
    localparam logic [3:0] S_DEL_CHK  = 4'd6;
    localparam logic [3:0] S_DEL_WR   = 4'd7;
    localparam logic [3:0] S_LIST_RD  = 4'd8;
    localparam logic [3:0] S_LIST_OUT = 4'd9;
    localparam logic [3:0] S_RESULT   = 4'd10;

    logic [3:0]                   state_reg, state_next;
    logic [ole_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic                         res_slot_reg, res_slot_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            res_status_reg <= ole_pkg::ST_OK;
            res_slot_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        cmd             = '0;
        cmd.ptr_op      = ole_pkg::PTR_HOLD;
        cmd.stop_op     = ole_pkg::STOP_HOLD;
        cmd.rd_sel      = ole_pkg::RD_PTR;
        cmd.status      = res_status_reg;
        cmd.slot_en     = res_slot_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE: begin
                res_slot_next = 1'b0;
                case (stat.op)
                    ole_pkg::OP_PUSH_FRONT, ole_pkg::OP_PUSH_BACK: begin
                        if (stat.full) begin
                            res_status_next = ole_pkg::ST_FULL;
                            state_next      = S_RESULT;
                        end else begin
                            cmd.ptr_op  = ole_pkg::PTR_COUNT;
                            cmd.stop_op = (stat.op == ole_pkg::OP_PUSH_FRONT) ?
                                          ole_pkg::STOP_ZERO : ole_pkg::STOP_COUNT;
                            state_next  = S_INS_CHK;
                        end
                    end
                    ole_pkg::OP_INSERT_AFTER: begin
                        if (stat.full) begin
                            res_status_next = ole_pkg::ST_FULL;
                            state_next      = S_RESULT;
                        end else if (stat.empty) begin
                            cmd.ptr_op  = ole_pkg::PTR_COUNT;
                            cmd.stop_op = ole_pkg::STOP_ZERO;
                            state_next  = S_INS_CHK;
                        end else if (stat.pos_beyond) begin
                            res_status_next = ole_pkg::ST_BAD_POS;
                            state_next      = S_RESULT;
                        end else begin
                            cmd.ptr_op  = ole_pkg::PTR_COUNT;
                            cmd.stop_op = ole_pkg::STOP_POS1;
                            state_next  = S_INS_CHK;
                        end
                    end
                    ole_pkg::OP_DELETE, ole_pkg::OP_SEARCH: begin
                        if (stat.empty) begin
                            res_status_next = ole_pkg::ST_EMPTY;
                            state_next      = S_RESULT;
                        end else begin
                            cmd.ptr_op = ole_pkg::PTR_ZERO;
                            state_next = S_SCAN_RD;
                        end
                    end
                    ole_pkg::OP_LIST: begin
                        if (stat.empty) begin
                            res_status_next = ole_pkg::ST_EMPTY;
                            state_next      = S_RESULT;
                        end else begin
                            cmd.ptr_op = ole_pkg::PTR_ZERO;
                            state_next = S_LIST_RD;
                        end
                    end
                    default: begin
                        // undefined opcode: dropped without a result
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_INS_CHK: begin
                if (stat.at_stop) begin
                    cmd.mem_wr      = 1'b1;
                    cmd.wr_value    = 1'b1;
                    cmd.cnt_inc     = 1'b1;
                    res_status_next = ole_pkg::ST_OK;
                    state_next      = S_RESULT;
                end else begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = ole_pkg::RD_PREV;
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR: begin
                // move the entry one slot toward the back
                cmd.mem_wr = 1'b1;
                cmd.ptr_op = ole_pkg::PTR_DEC;
                state_next = S_INS_CHK;
            end
            S_SCAN_RD: begin
                if (stat.at_end) begin
                    res_status_next = ole_pkg::ST_NOT_FOUND;
                    state_next      = S_RESULT;
                end else begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (stat.match) begin
                    if (stat.op == ole_pkg::OP_SEARCH) begin
                        res_status_next = ole_pkg::ST_OK;
                        res_slot_next   = 1'b1;
                        state_next      = S_RESULT;
                    end else begin
                        state_next = S_DEL_CHK;
                    end
                end else begin
                    cmd.ptr_op = ole_pkg::PTR_INC;
                    state_next = S_SCAN_RD;
                end
            end
            S_DEL_CHK: begin
                if (stat.del_end) begin
                    cmd.cnt_dec     = 1'b1;
                    res_status_next = ole_pkg::ST_OK;
                    state_next      = S_RESULT;
                end else begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = ole_pkg::RD_NEXT;
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                // close the gap left by the deleted entry
                cmd.mem_wr = 1'b1;
                cmd.ptr_op = ole_pkg::PTR_INC;
                state_next = S_DEL_CHK;
            end
            S_LIST_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = S_LIST_OUT;
            end
            S_LIST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_list = 1'b1;
                    cmd.status   = ole_pkg::ST_OK;
                    if (stat.list_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.ptr_op = ole_pkg::PTR_INC;
                        state_next = S_LIST_RD;
                    end
                end
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/ole_dpath.sv]
// ----------------------------------------------------------------------------
// ole_dpath
// entry memory, count and pointer registers, compare logic, result register
// ----------------------------------------------------------------------------
`include "ordered_list_engine_defines.svh"

module ole_dpath #(
    parameter int CAPACITY = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ole_pkg::cmd_t                       cmd,
    output ole_pkg::stat_t                      stat,
    input  logic [ole_pkg::OPCODE_W-1:0]        s_opcode,
    input  logic signed [ole_pkg::VALUE_W-1:0]  s_value,
    input  logic [ole_pkg::POSITION_W-1:0]      s_position,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ole_pkg::STATUS_W-1:0]        m_status,
    output logic signed [ole_pkg::VALUE_W-1:0]  m_element,
    output logic [ole_pkg::SLOT_W-1:0]          m_slot_index,
    output logic [ole_pkg::LENGTH_W-1:0]        m_length,
    output logic                                m_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    logic [ole_pkg::VALUE_W-1:0] mem [CAPACITY];

    logic [ole_pkg::OPCODE_W-1:0]   op_reg;
    logic [ole_pkg::VALUE_W-1:0]    value_reg;
    logic [ole_pkg::POSITION_W-1:0] pos_reg;
    logic [CW-1:0]                  count_reg, count_next;
    logic [CW-1:0]                  ptr_reg, ptr_next;
    logic [CW-1:0]                  stop_reg, stop_next;
    logic [ole_pkg::VALUE_W-1:0]    rdata_reg;
    logic [CW-1:0]                  rd_full;
    logic [AW-1:0]                  rd_addr;
    logic [AW-1:0]                  wr_addr;
    logic [ole_pkg::VALUE_W-1:0]    wr_data;
    logic [CW-1:0]                  ptr_plus1;

    logic                           m_valid_reg;
    logic [ole_pkg::STATUS_W-1:0]   m_status_reg;
    logic [ole_pkg::VALUE_W-1:0]    m_element_reg;
    logic [ole_pkg::SLOT_W-1:0]     m_slot_reg;
    logic [ole_pkg::LENGTH_W-1:0]   m_length_reg;
    logic                           m_last_reg;

    assign ptr_plus1 = ptr_reg + CW'(1);

    always_comb begin
        case (cmd.rd_sel)
            ole_pkg::RD_PREV: rd_full = ptr_reg - CW'(1);
            ole_pkg::RD_NEXT: rd_full = ptr_plus1;
            default:          rd_full = ptr_reg;
        endcase
    end

    assign rd_addr = rd_full[AW-1:0];
    assign wr_addr = ptr_reg[AW-1:0];
    assign wr_data = cmd.wr_value ? value_reg : rdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            op_reg    <= s_opcode;
            value_reg <= s_value;
            pos_reg   <= s_position;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.cnt_inc) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.cnt_dec) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb begin
        case (cmd.ptr_op)
            ole_pkg::PTR_ZERO:  ptr_next = '0;
            ole_pkg::PTR_COUNT: ptr_next = count_reg;
            ole_pkg::PTR_INC:   ptr_next = ptr_plus1;
            ole_pkg::PTR_DEC:   ptr_next = ptr_reg - CW'(1);
            default:            ptr_next = ptr_reg;
        endcase
    end

    // insertion point for insert-after is one past the given position
    always_comb begin
        case (cmd.stop_op)
            ole_pkg::STOP_ZERO:  stop_next = '0;
            ole_pkg::STOP_COUNT: stop_next = count_reg;
            ole_pkg::STOP_POS1:  stop_next = CW'(pos_reg) + CW'(1);
            default:             stop_next = stop_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        ptr_reg  <= ptr_next;
        stop_reg <= stop_next;
    end

    always_comb begin
        stat.op         = op_reg;
        stat.empty      = (count_reg == '0);
        stat.full       = (count_reg == CW'(CAPACITY));
        stat.pos_beyond = (32'(pos_reg) >= 32'(count_reg));
        stat.at_stop    = (ptr_reg == stop_reg);
        stat.at_end     = (ptr_reg == count_reg);
        stat.del_end    = (ptr_plus1 == count_reg);
        stat.match      = (rdata_reg == value_reg);
        stat.list_last  = (ptr_plus1 == count_reg) ||
                          (32'(ptr_reg) == ole_pkg::MAX_RESULTS - 1);
        stat.out_free   = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg  <= cmd.status;
            m_element_reg <= cmd.out_list ? rdata_reg : '0;
            m_slot_reg    <= (cmd.out_list || cmd.slot_en) ?
                             ole_pkg::SLOT_W'(ptr_reg) : '0;
            m_length_reg  <= ole_pkg::LENGTH_W'(count_reg);
            m_last_reg    <= cmd.out_list ? stat.list_last : 1'b1;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_element    = m_element_reg;
    assign m_slot_index = m_slot_reg;
    assign m_length     = m_length_reg;
    assign m_last       = m_last_reg;

    `OLE_ALWAYS(a_count_bound, 32'(count_reg) <= CAPACITY, "entry count beyond capacity")
    `OLE_IMPLIES(a_wr_in_range, cmd.mem_wr, 32'(ptr_reg) < CAPACITY, "write past the end")
    `OLE_IMPLIES(a_load_free, cmd.out_load, stat.out_free, "result overwritten before taken")
    `OLE_NEXT(a_insert_grows, cmd.cnt_inc, count_reg == $past(count_reg) + CW'(1), "count lost")

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the ordered list engine: a directed table of
// requests, then biased random requests; every result is compared in order
// against a behavioral copy of the list kept inside the bench, or against
// the single result typed into the table for a fixed step
module tb;
    import ole_pkg::*;

    localparam int CAPACITY         = 16;
    localparam int RANDOM_REQUESTS  = 240;
    localparam int RANDOM_PHASES    = 6;
    localparam int DRAIN_CYCLES     = 60;
    localparam int LONG_HOLD_CYCLES = 300;

    localparam logic [OPCODE_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_7 = 3'd7;
    localparam logic [VALUE_W-1:0]  VAL_MIN     = 32'h8000_0000;
    localparam logic [VALUE_W-1:0]  VAL_MAX     = 32'h7fff_ffff;
    localparam logic [VALUE_W-1:0]  VAL_ONES    = 32'hffff_ffff;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  element;
        logic [SLOT_W-1:0]   slot;
        logic [LENGTH_W-1:0] length;
        logic                last;
    } list_result_t;

    typedef struct {
        logic [OPCODE_W-1:0]   op;
        logic [VALUE_W-1:0]    value;
        logic [POSITION_W-1:0] pos;
        bit                    fixed;   // single result typed into the table
        logic [STATUS_W-1:0]   status;
        logic [SLOT_W-1:0]     slot;
        logic [LENGTH_W-1:0]   length;
    } list_request_t;

    logic                       aclk         = 1'b0;
    logic                       aresetn      = 1'b0;
    logic                       s_valid      = 1'b0;
    logic                       s_ready;
    logic [OPCODE_W-1:0]        s_opcode     = '0;
    logic signed [VALUE_W-1:0]  s_value      = '0;
    logic [POSITION_W-1:0]      s_position   = '0;
    logic                       m_valid;
    logic                       m_ready      = 1'b0;
    logic [STATUS_W-1:0]        m_status;
    logic signed [VALUE_W-1:0]  m_element;
    logic [SLOT_W-1:0]          m_slot_index;
    logic [LENGTH_W-1:0]        m_length;
    logic                       m_last;

    // behavioral list
    logic [VALUE_W-1:0] model_entries [CAPACITY];
    int                 model_count = 0;

    list_result_t  pending_results[$];
    list_request_t directed_steps[$];
    logic [OPCODE_W-1:0] insert_ops [3] = '{OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AFTER};

    int mismatches      = 0;
    int results_checked = 0;
    int requests_sent   = 0;
    int ignored_sent    = 0;
    int status_tally [8] = '{default: 0};
    bit steady       = 1'b0;
    bit hold_request = 1'b0;

    ordered_list_engine #(
        .CAPACITY(CAPACITY)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_value     (s_value),
        .s_position  (s_position),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_element   (m_element),
        .m_slot_index(m_slot_index),
        .m_length    (m_length),
        .m_last      (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic list_result_t model_result(input logic [STATUS_W-1:0] status,
                                                  input logic [VALUE_W-1:0] element,
                                                  input int slot, input bit last);
        list_result_t r;
        r.status  = status;
        r.element = element;
        r.slot    = SLOT_W'(slot);
        r.length  = LENGTH_W'(model_count);
        r.last    = last;
        return r;
    endfunction

    // applies one request to the behavioral list and returns its results
    function automatic void model_request(input logic [OPCODE_W-1:0] op,
                                          input logic [VALUE_W-1:0] value,
                                          input logic [POSITION_W-1:0] pos,
                                          output list_result_t res[$]);
        int k;
        int at;
        int hit;
        int n;
        res = {};
        hit = model_count;
        for (k = model_count - 1; k >= 0; k--) begin
            if (model_entries[k] == value) hit = k;
        end
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AFTER: begin
                if (model_count >= CAPACITY) begin
                    res.push_back(model_result(ST_FULL, '0, 0, 1'b1));
                end else if (op == OP_INSERT_AFTER && model_count != 0
                             && int'(pos) >= model_count) begin
                    res.push_back(model_result(ST_BAD_POS, '0, 0, 1'b1));
                end else begin
                    if (op == OP_PUSH_FRONT || model_count == 0) at = 0;
                    else if (op == OP_PUSH_BACK) at = model_count;
                    else at = int'(pos) + 1;
                    for (k = model_count; k > at; k--) model_entries[k] = model_entries[k-1];
                    model_entries[at] = value;
                    model_count++;
                    res.push_back(model_result(ST_OK, '0, 0, 1'b1));
                end
            end
            OP_DELETE, OP_SEARCH: begin
                if (model_count == 0) begin
                    res.push_back(model_result(ST_EMPTY, '0, 0, 1'b1));
                end else if (hit >= model_count) begin
                    res.push_back(model_result(ST_NOT_FOUND, '0, 0, 1'b1));
                end else if (op == OP_DELETE) begin
                    for (k = hit; k + 1 < model_count; k++) model_entries[k] = model_entries[k+1];
                    model_count--;
                    res.push_back(model_result(ST_OK, '0, 0, 1'b1));
                end else begin
                    res.push_back(model_result(ST_OK, '0, hit, 1'b1));
                end
            end
            OP_LIST: begin
                if (model_count == 0) begin
                    res.push_back(model_result(ST_EMPTY, '0, 0, 1'b1));
                end else begin
                    n = (model_count < MAX_RESULTS) ? model_count : MAX_RESULTS;
                    for (k = 0; k < n; k++)
                        res.push_back(model_result(ST_OK, model_entries[k], k, k + 1 == n));
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (model_count > 0 && r < 50) return model_entries[$urandom_range(0, model_count - 1)];
        if (r < 75) return VALUE_W'($urandom_range(0, 6)) - 32'd3;
        if (r < 80) return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
        return $urandom;
    endfunction

    function automatic list_request_t random_request(input bit grow);
        list_request_t req;
        int r;
        req.fixed  = 1'b0;
        req.status = ST_OK;
        req.slot   = '0;
        req.length = '0;
        req.value  = pick_value();
        if (model_count > 0 && $urandom_range(0, 4) != 0)
            req.pos = POSITION_W'($urandom_range(0, model_count - 1));
        else
            req.pos = POSITION_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 4) req.op = r[0] ? OP_UNUSED_7 : OP_UNUSED_6;
        else if (r < 14) req.op = OP_LIST;
        else if (r < (grow ? 70 : 28)) req.op = insert_ops[$urandom_range(0, 2)];
        else if (r < (grow ? 85 : 78)) req.op = OP_DELETE;
        else req.op = OP_SEARCH;
        return req;
    endfunction

    function automatic void add_step(input logic [OPCODE_W-1:0] op,
                                     input logic [VALUE_W-1:0] value,
                                     input logic [POSITION_W-1:0] pos,
                                     input bit fixed = 1'b0,
                                     input logic [STATUS_W-1:0] status = ST_OK,
                                     input logic [SLOT_W-1:0] slot = '0,
                                     input logic [LENGTH_W-1:0] length = '0);
        list_request_t step;
        step.op     = op;
        step.value  = value;
        step.pos    = pos;
        step.fixed  = fixed;
        step.status = status;
        step.slot   = slot;
        step.length = length;
        directed_steps.push_back(step);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_request(input list_request_t req);
        list_result_t res[$];
        list_result_t want;
        int gap;
        s_opcode   <= req.op;
        s_value    <= req.value;
        s_position <= req.pos;
        s_valid    <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        model_request(req.op, req.value, req.pos, res);
        if (req.fixed) begin
            want.status  = req.status;
            want.element = '0;
            want.slot    = req.slot;
            want.length  = req.length;
            want.last    = 1'b1;
            pending_results.push_back(want);
        end else begin
            foreach (res[i]) pending_results.push_back(res[i]);
        end
        requests_sent++;
        if (req.op > OP_LIST) ignored_sent++;
        @(negedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got status %0d element %0h",
                         $time, m_status, m_element);
            end else begin
                want = pending_results.pop_front();
                status_tally[want.status]++;
                check_field("status", 32'(want.status), 32'(m_status));
                check_field("element", want.element, m_element);
                check_field("slot_index", 32'(want.slot), 32'(m_slot_index));
                check_field("length", 32'(want.length), 32'(m_length));
                check_field("last", 32'(want.last), 32'(m_last));
            end
        end
    end

    // result side: random stalls, plus one long hold-off to back the block up
    initial begin
        int stall;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end
        end
    end

    initial begin
        #(8_000_000);
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        int phase;
        int n;
        list_request_t req;

        // empty list
        add_step(OP_LIST, '0, '0, 1'b1, ST_EMPTY, '0, 5'd0);
        add_step(OP_SEARCH, '0, '0, 1'b1, ST_EMPTY, '0, 5'd0);
        add_step(OP_DELETE, '0, '0, 1'b1, ST_EMPTY, '0, 5'd0);
        add_step(OP_UNUSED_6, VAL_ONES, 4'd15);
        // insert after on an empty list ignores the position
        add_step(OP_INSERT_AFTER, '0, 4'd15, 1'b1, ST_OK, '0, 5'd1);
        add_step(OP_PUSH_FRONT, VAL_MIN, '0, 1'b1, ST_OK, '0, 5'd2);
        add_step(OP_PUSH_BACK, VAL_MAX, '0, 1'b1, ST_OK, '0, 5'd3);
        add_step(OP_INSERT_AFTER, 32'd77, 4'd3, 1'b1, ST_BAD_POS, '0, 5'd3);
        add_step(OP_INSERT_AFTER, VAL_ONES, 4'd2, 1'b1, ST_OK, '0, 5'd4);
        add_step(OP_SEARCH, VAL_MAX, '0, 1'b1, ST_OK, 4'd2, 5'd4);
        add_step(OP_DELETE, 32'd12345, '0, 1'b1, ST_NOT_FOUND, '0, 5'd4);
        add_step(OP_UNUSED_7, 32'd5, '0);
        // fill up, with duplicates of 5 to check first-match behavior
        add_step(OP_PUSH_BACK, 32'd5, '0);
        add_step(OP_PUSH_FRONT, 32'd5, '0);
        add_step(OP_INSERT_AFTER, 32'h5555_5555, 4'd5);
        add_step(OP_INSERT_AFTER, 32'haaaa_aaaa, 4'd0);
        add_step(OP_PUSH_BACK, 32'h0000_ffff, '0);
        add_step(OP_PUSH_FRONT, 32'hffff_0000, '0);
        add_step(OP_INSERT_AFTER, 32'd7, 4'd9);
        add_step(OP_PUSH_BACK, 32'd5, '0);
        add_step(OP_PUSH_BACK, 32'hffff_fffe, '0);
        add_step(OP_PUSH_FRONT, 32'd5, '0);
        add_step(OP_INSERT_AFTER, 32'd9, 4'd13);
        add_step(OP_INSERT_AFTER, 32'd10, 4'd15, 1'b1, ST_BAD_POS, '0, 5'd15);
        add_step(OP_INSERT_AFTER, 32'd11, 4'd14, 1'b1, ST_OK, '0, 5'd16);
        // full list: full check wins over the position check
        add_step(OP_PUSH_FRONT, 32'd1, '0, 1'b1, ST_FULL, '0, 5'd16);
        add_step(OP_INSERT_AFTER, 32'd1, 4'd15, 1'b1, ST_FULL, '0, 5'd16);
        add_step(OP_PUSH_BACK, 32'd1, '0, 1'b1, ST_FULL, '0, 5'd16);
        add_step(OP_LIST, '0, '0);
        add_step(OP_DELETE, 32'd5, '0);
        add_step(OP_SEARCH, 32'd5, '0);
        add_step(OP_SEARCH, VAL_ONES, '0);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_steps[i]) send_request(directed_steps[i]);

        // even phases grow the list, odd phases drain it
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            steady = (phase == 3);
            if (phase == 1) hold_request = 1'b1;
            n = 0;
            while (n < RANDOM_REQUESTS / RANDOM_PHASES) begin
                req = random_request(phase % 2 == 0);
                send_request(req);
                if (req.op <= OP_LIST) n++;
            end
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb: %0d requests sent (%0d with undefined opcodes), %0d results checked",
                 requests_sent, ignored_sent, results_checked);
        $display("tb: statuses ok %0d, not found %0d, full %0d, bad position %0d, empty %0d",
                 status_tally[ST_OK], status_tally[ST_NOT_FOUND], status_tally[ST_FULL],
                 status_tally[ST_BAD_POS], status_tally[ST_EMPTY]);
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/ole_pkg.sv
rtl/ole_ctrl.sv
rtl/ole_dpath.sv
rtl/ordered_list_engine.sv
tb/sv/tb.sv
